@@ hw/rtl/cli_pkg.sv @@
// Shared types and constants for the circle and line intersection block.
package cli_pkg;

    // Coordinate width of every Q8.8 point field.
    localparam int COORD_WIDTH = 16;
    localparam int CW          = COORD_WIDTH;
    // Point differences, squared length, cross term and discriminant.
    localparam int EW     = CW + 1;
    localparam int LW     = 2 * EW;
    localparam int KW     = 2 * EW + 1;
    localparam int RADW   = CW - 1;
    localparam int R2W    = 2 * RADW;
    localparam int DW     = 2 * KW + 1;
    localparam int SQW    = 4 * CW - 1;
    localparam int RTW    = 2 * CW;
    localparam int THRW   = 63;
    localparam int CMPW   = (SQW > THRW) ? SQW : THRW;
    // Numerators and the divider.
    localparam int PW     = KW + EW;
    localparam int NW     = PW + 1;
    localparam int NUMW   = NW + 1;
    localparam int QW     = CW + 2;
    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    // Configuration port.
    localparam int ADDRW  = 4;
    localparam int APB_DW = 64;
    localparam logic [ADDRW-4:0] REG_TANGENT_THRESHOLD = '0;

    // Hit count codes.
    localparam logic [1:0] HITS_NONE = 2'd0;
    localparam logic [1:0] HITS_ONE  = 2'd1;
    localparam logic [1:0] HITS_TWO  = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic [RADW-1:0]      radius;
        logic signed [CW-1:0] line_ax;
        logic signed [CW-1:0] line_ay;
        logic signed [CW-1:0] line_bx;
        logic signed [CW-1:0] line_by;
    } in_t;

    typedef struct packed {
        logic [1:0]           hit_count;
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic                 degenerate;
    } out_t;

    // One classified request as it waits between front and back.
    typedef struct packed {
        logic [LW-1:0]        len2;
        logic signed [KW-1:0] k;
        logic [R2W-1:0]       r2;
        logic signed [EW-1:0] ex;
        logic signed [EW-1:0] ey;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 degen;
    } q_t;

endpackage

@@ hw/rtl/circle_line_intersection.sv @@
// Top level of the circle and line intersection block.
//
//  channel  | handshake        | payload            | moves
//  ---------+------------------+--------------------+--------------------------
//  s_       | s_valid/s_ready  | s_data (in_t)      | one query request
//  m_       | m_valid/m_ready  | m_data (out_t)     | one result per request
//  APB      | psel/penable     | paddr/pwdata       | tangent_threshold at 0x0
//
//  One request enters per clock unless a full queue holds the front; each
//  request passes the front, the queue, the product stages, the 32-stage
//  square-root pipeline and the 18-stage divider.
//  Reset (aresetn low, synchronous) empties every stage and clears the threshold.
//  A held result stalls the back part; the queue lets the front keep accepting
//  until it fills.
module circle_line_intersection (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  cli_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output cli_pkg::out_t                m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cli_pkg::ADDRW-1:0]    paddr,
    input  logic [cli_pkg::APB_DW-1:0]   pwdata,
    output logic [cli_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import cli_pkg::*;

    logic            push_valid, push_ready, pop_valid, pop_ready;
    q_t              push_data, pop_data;
    logic [THRW-1:0] thr_reg;
    logic            reg_hit;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_hit = paddr[ADDRW-1:3] == REG_TANGENT_THRESHOLD;
    assign prdata  = reg_hit ? APB_DW'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            thr_reg <= pwdata[THRW-1:0];
        end
    end

    cli_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    cli_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cli_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .thr       (thr_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ hw/rtl/cli_front.sv @@
// Front part: accepts requests, moves them to the circle frame, forms L and K.
module cli_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cli_pkg::in_t  s_data,
    output logic          push_valid,
    input  logic          push_ready,
    output cli_pkg::q_t   push_data
);
    import cli_pkg::*;

    logic fen;
    logic f1_v_reg, f2_v_reg, f3_v_reg;

    logic signed [EW-1:0] ex_next, ey_next, px_next, py_next, qx_next, qy_next;
    logic signed [EW-1:0] ex_reg, ey_reg, px_reg, py_reg, qx_reg, qy_reg;
    logic [RADW-1:0]      rad_reg;
    logic signed [CW-1:0] cx1_reg, cy1_reg;
    logic                 dg1_reg;

    logic [LW-1:0]          ex2_reg, ey2_reg;
    logic signed [2*EW-1:0] pq_reg, qp_reg;
    logic [R2W-1:0]         r2_reg;
    logic signed [EW-1:0]   ex2p_reg, ey2p_reg;
    logic signed [CW-1:0]   cx2_reg, cy2_reg;
    logic                   dg2_reg;

    q_t f3_reg;

    // The whole front moves together unless its last stage is stuck.
    assign fen        = !f3_v_reg || push_ready;
    assign s_ready    = fen;
    assign push_valid = f3_v_reg;
    assign push_data  = f3_reg;

    // Differences, sign extended by one bit.
    assign ex_next = {s_data.line_bx[CW-1], s_data.line_bx}
                   - {s_data.line_ax[CW-1], s_data.line_ax};
    assign ey_next = {s_data.line_by[CW-1], s_data.line_by}
                   - {s_data.line_ay[CW-1], s_data.line_ay};
    assign px_next = {s_data.line_ax[CW-1], s_data.line_ax}
                   - {s_data.center_x[CW-1], s_data.center_x};
    assign py_next = {s_data.line_ay[CW-1], s_data.line_ay}
                   - {s_data.center_y[CW-1], s_data.center_y};
    assign qx_next = {s_data.line_bx[CW-1], s_data.line_bx}
                   - {s_data.center_x[CW-1], s_data.center_x};
    assign qy_next = {s_data.line_by[CW-1], s_data.line_by}
                   - {s_data.center_y[CW-1], s_data.center_y};

    // Valid bits of the three front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else if (fen) begin
            f1_v_reg <= s_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    // Stage one: frame shift and the coincident-point check.
    always_ff @(posedge aclk) begin
        if (fen) begin
            ex_reg  <= ex_next;
            ey_reg  <= ey_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            rad_reg <= s_data.radius;
            cx1_reg <= s_data.center_x;
            cy1_reg <= s_data.center_y;
            dg1_reg <= (ex_next == '0) && (ey_next == '0);
        end
    end

    // Stage two: the products.
    always_ff @(posedge aclk) begin
        if (fen) begin
            ex2_reg  <= LW'(ex_reg * ex_reg);
            ey2_reg  <= LW'(ey_reg * ey_reg);
            pq_reg   <= (2*EW)'(px_reg) * (2*EW)'(qy_reg);
            qp_reg   <= (2*EW)'(qx_reg) * (2*EW)'(py_reg);
            r2_reg   <= R2W'(rad_reg) * R2W'(rad_reg);
            ex2p_reg <= ex_reg;
            ey2p_reg <= ey_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            dg2_reg  <= dg1_reg;
        end
    end

    // Stage three: squared length and cross term.
    always_ff @(posedge aclk) begin
        if (fen) begin
            f3_reg.len2  <= ex2_reg + ey2_reg;
            f3_reg.k     <= KW'(pq_reg) - KW'(qp_reg);
            f3_reg.r2    <= r2_reg;
            f3_reg.ex    <= ex2p_reg;
            f3_reg.ey    <= ey2p_reg;
            f3_reg.cx    <= cx2_reg;
            f3_reg.cy    <= cy2_reg;
            f3_reg.degen <= dg2_reg;
        end
    end

endmodule

@@ hw/rtl/cli_fifo.sv @@
// Short queue that decouples the front part from the back part.
module cli_fifo (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  cli_pkg::q_t push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output cli_pkg::q_t pop_data
);
    import cli_pkg::*;

    q_t             mem_reg [FIFO_DEPTH];
    logic [FAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FAW:0]   count_reg;
    logic           do_push, do_pop;

    assign push_ready = count_reg != (FAW+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/cli_back.sv @@
// Back part: discriminant, pipelined square root, four pipelined dividers, output.
module cli_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  cli_pkg::q_t               pop_data,
    input  logic [cli_pkg::THRW-1:0]  thr,
    output logic                      m_valid,
    input  logic                      m_ready,
    output cli_pkg::out_t             m_data
);
    import cli_pkg::*;

    typedef struct packed {
        logic [RTW+1:0]       rem;
        logic [RTW-1:0]       root;
        logic [2*RTW-1:0]     rad;
        logic signed [PW-1:0] kx;
        logic signed [PW-1:0] ky;
        logic signed [EW-1:0] sex;
        logic signed [EW-1:0] aey;
        logic [LW-1:0]        len2;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 gt;
        logic                 neg;
        logic                 degen;
    } sq_t;

    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [QW-1:0]   quo;
        logic            sgn;
    } lane_t;

    typedef struct packed {
        lane_t [3:0]          lane;
        logic [LW:0]          den;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 gt;
        logic                 neg;
        logic                 degen;
    } dv_t;

    localparam logic signed [QW+1:0] SMAX = (QW+2)'(2 ** (CW - 1) - 1);
    localparam logic signed [QW+1:0] SMIN = -SMAX - 1;

    logic ben;
    logic m_valid_reg;
    out_t m_data_reg;

    // The back pipeline stalls only when the output register is held.
    assign ben       = !m_valid_reg || m_ready;
    assign pop_ready = ben;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Stage B1: the wide products.
    logic                     b1_v_reg;
    logic [R2W+LW-1:0]        r2l_reg;
    logic signed [2*KW-1:0]   k2_reg;
    logic signed [PW-1:0]     kx_reg, ky_reg;
    logic signed [EW-1:0]     ex_reg, ey_reg;
    logic [LW-1:0]            len2_reg;
    logic signed [CW-1:0]     cx_reg, cy_reg;
    logic                     dg_reg;

    always_ff @(posedge aclk) begin
        if (ben) begin
            r2l_reg  <= (R2W+LW)'(pop_data.r2) * (R2W+LW)'(pop_data.len2);
            k2_reg   <= (2*KW)'(pop_data.k) * (2*KW)'(pop_data.k);
            kx_reg   <= PW'(pop_data.k) * PW'(pop_data.ey);
            ky_reg   <= -(PW'(pop_data.k) * PW'(pop_data.ex));
            ex_reg   <= pop_data.ex;
            ey_reg   <= pop_data.ey;
            len2_reg <= pop_data.len2;
            cx_reg   <= pop_data.cx;
            cy_reg   <= pop_data.cy;
            dg_reg   <= pop_data.degen;
        end
    end

    // Stage B2: discriminant, its sign and the tangency compare.
    logic signed [DW-1:0] disc_w;
    logic [SQW-1:0]       dsq_w;
    sq_t                  sq_reg [0:RTW];
    logic                 sv_reg [0:RTW];

    assign disc_w = $signed({{(DW-R2W-LW){1'b0}}, r2l_reg})
                  - $signed({{(DW-2*KW){k2_reg[2*KW-1]}}, k2_reg});
    assign dsq_w  = disc_w[SQW-1:0];

    always_ff @(posedge aclk) begin
        if (ben) begin
            sq_reg[0].rem   <= '0;
            sq_reg[0].root  <= '0;
            sq_reg[0].rad   <= (2*RTW)'(dsq_w);
            sq_reg[0].kx    <= kx_reg;
            sq_reg[0].ky    <= ky_reg;
            sq_reg[0].sex   <= ey_reg[EW-1] ? -ex_reg : ex_reg;
            sq_reg[0].aey   <= ey_reg[EW-1] ? -ey_reg : ey_reg;
            sq_reg[0].len2  <= len2_reg;
            sq_reg[0].cx    <= cx_reg;
            sq_reg[0].cy    <= cy_reg;
            sq_reg[0].gt    <= CMPW'(dsq_w) > CMPW'(thr);
            sq_reg[0].neg   <= disc_w[DW-1];
            sq_reg[0].degen <= dg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg  <= 1'b0;
            sv_reg[0] <= 1'b0;
        end else if (ben) begin
            b1_v_reg  <= pop_valid;
            sv_reg[0] <= b1_v_reg;
        end
    end

    // Square root: one result bit per stage, two radicand bits shifted in each time.
    for (genvar i = 0; i < RTW; i++) begin : g_sqrt
        logic [RTW+1:0] cur_w, trial_w;
        logic           ge_w;
        sq_t            nx_w;

        assign cur_w   = {sq_reg[i].rem[RTW-1:0], sq_reg[i].rad[2*RTW-1 -: 2]};
        assign trial_w = {sq_reg[i].root, 2'b01};
        assign ge_w    = cur_w >= trial_w;

        // Next stage contents with this stage's root bit applied.
        always_comb begin
            nx_w      = sq_reg[i];
            nx_w.rem  = ge_w ? (cur_w - trial_w) : cur_w;
            nx_w.root = {sq_reg[i].root[RTW-2:0], ge_w};
            nx_w.rad  = sq_reg[i].rad << 2;
        end

        always_ff @(posedge aclk) begin
            if (ben) begin
                sq_reg[i+1] <= nx_w;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[i+1] <= 1'b0;
            end else if (ben) begin
                sv_reg[i+1] <= sv_reg[i];
            end
        end
    end

    // Stage M1: root times the direction terms.
    logic                      m1_v_reg;
    logic signed [EW+RTW:0]    ux_reg, uy_reg;
    logic signed [PW-1:0]      m1kx_reg, m1ky_reg;
    logic [LW-1:0]             m1len_reg;
    logic signed [CW-1:0]      m1cx_reg, m1cy_reg;
    logic                      m1gt_reg, m1neg_reg, m1dg_reg;

    always_ff @(posedge aclk) begin
        if (ben) begin
            ux_reg    <= (EW+RTW+1)'(sq_reg[RTW].sex)
                       * (EW+RTW+1)'($signed({1'b0, sq_reg[RTW].root}));
            uy_reg    <= (EW+RTW+1)'(sq_reg[RTW].aey)
                       * (EW+RTW+1)'($signed({1'b0, sq_reg[RTW].root}));
            m1kx_reg  <= sq_reg[RTW].kx;
            m1ky_reg  <= sq_reg[RTW].ky;
            m1len_reg <= sq_reg[RTW].len2;
            m1cx_reg  <= sq_reg[RTW].cx;
            m1cy_reg  <= sq_reg[RTW].cy;
            m1gt_reg  <= sq_reg[RTW].gt;
            m1neg_reg <= sq_reg[RTW].neg;
            m1dg_reg  <= sq_reg[RTW].degen;
        end
    end

    // Stage M2: the four numerators.
    logic                 m2_v_reg;
    logic signed [NW-1:0] num_reg [4];
    logic [LW-1:0]        m2len_reg;
    logic signed [CW-1:0] m2cx_reg, m2cy_reg;
    logic                 m2gt_reg, m2neg_reg, m2dg_reg;

    always_ff @(posedge aclk) begin
        if (ben) begin
            num_reg[0] <= NW'(m1kx_reg) + NW'(ux_reg);
            num_reg[1] <= NW'(m1ky_reg) + NW'(uy_reg);
            num_reg[2] <= NW'(m1kx_reg) - NW'(ux_reg);
            num_reg[3] <= NW'(m1ky_reg) - NW'(uy_reg);
            m2len_reg  <= m1len_reg;
            m2cx_reg   <= m1cx_reg;
            m2cy_reg   <= m1cy_reg;
            m2gt_reg   <= m1gt_reg;
            m2neg_reg  <= m1neg_reg;
            m2dg_reg   <= m1dg_reg;
        end
    end

    // Stage M3: rounding setup, 2|n| + L over 2L.
    dv_t  dv_reg [0:QW];
    logic dvv_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (ben) begin
            for (int j = 0; j < 4; j++) begin
                dv_reg[0].lane[j].sgn <= num_reg[j][NW-1];
                dv_reg[0].lane[j].quo <= '0;
                dv_reg[0].lane[j].rem <=
                    {(num_reg[j][NW-1] ? NW'(-num_reg[j]) : NW'(num_reg[j])), 1'b0}
                    + NUMW'(m2len_reg);
            end
            dv_reg[0].den   <= {m2len_reg, 1'b0};
            dv_reg[0].cx    <= m2cx_reg;
            dv_reg[0].cy    <= m2cy_reg;
            dv_reg[0].gt    <= m2gt_reg;
            dv_reg[0].neg   <= m2neg_reg;
            dv_reg[0].degen <= m2dg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg   <= 1'b0;
            m2_v_reg   <= 1'b0;
            dvv_reg[0] <= 1'b0;
        end else if (ben) begin
            m1_v_reg   <= sv_reg[RTW];
            m2_v_reg   <= m1_v_reg;
            dvv_reg[0] <= m2_v_reg;
        end
    end

    // Restoring division, one quotient bit per stage, top bit first.
    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int BIT = QW - 1 - s;
        logic [NUMW-1:0] dk_w;
        dv_t             nd_w;

        assign dk_w = NUMW'(dv_reg[s].den) << BIT;

        always_comb begin
            nd_w = dv_reg[s];
            for (int j = 0; j < 4; j++) begin
                if (dv_reg[s].lane[j].rem >= dk_w) begin
                    nd_w.lane[j].rem      = dv_reg[s].lane[j].rem - dk_w;
                    nd_w.lane[j].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ben) begin
                dv_reg[s+1] <= nd_w;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvv_reg[s+1] <= 1'b0;
            end else if (ben) begin
                dvv_reg[s+1] <= dvv_reg[s];
            end
        end
    end

    // Sign, clamp, move back by the center and saturate each lane.
    logic signed [CW-1:0] pt_w [4];

    always_comb begin
        logic [QW-1:0]        mag;
        logic signed [QW:0]   sval;
        logic signed [QW+1:0] sum;
        logic signed [CW-1:0] ctr;
        for (int j = 0; j < 4; j++) begin
            mag  = dv_reg[QW].lane[j].quo[QW-1] ? {1'b1, {(QW-1){1'b0}}}
                                                : dv_reg[QW].lane[j].quo;
            sval = dv_reg[QW].lane[j].sgn ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            ctr  = (j % 2 == 0) ? dv_reg[QW].cx : dv_reg[QW].cy;
            sum  = (QW+2)'(sval) + (QW+2)'(ctr);
            if (sum > SMAX) begin
                pt_w[j] = CW'(SMAX);
            end else if (sum < SMIN) begin
                pt_w[j] = CW'(SMIN);
            end else begin
                pt_w[j] = CW'(sum);
            end
        end
    end

    // Output register: the result fields for the hit classes.
    out_t res_w;

    always_comb begin
        res_w            = '0;
        res_w.degenerate = dv_reg[QW].degen;
        if (!dv_reg[QW].degen && !dv_reg[QW].neg) begin
            res_w.hit_count = dv_reg[QW].gt ? HITS_TWO : HITS_ONE;
            res_w.first_x   = pt_w[0];
            res_w.first_y   = pt_w[1];
            if (dv_reg[QW].gt) begin
                res_w.second_x = pt_w[2];
                res_w.second_y = pt_w[3];
            end
        end else begin
            res_w.hit_count = HITS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ben) begin
            m_valid_reg <= dvv_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ben) begin
            m_data_reg <= res_w;
        end
    end

endmodule

@@ hw/rtl/cli_checker.sv @@
// Port-level checks of the intersection block, bound to its top level.
module cli_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input cli_pkg::out_t                m_data,
    input logic                         pready
);
    import cli_pkg::*;

    // A held result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Coincident line points give no hits and zero points.
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.hit_count == HITS_NONE
            && m_data.first_x == '0 && m_data.first_y == '0)
        else $error("degenerate result carries hits");

    // Second point fields are zero unless two hits are reported.
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit_count != HITS_TWO |->
            m_data.second_x == '0 && m_data.second_y == '0)
        else $error("unused second point not cleared");

    // No result leaves the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The configuration port never waits.
    a_pready: assert property (@(posedge aclk) pready)
        else $error("configuration port not ready");

endmodule

bind circle_line_intersection cli_checker u_cli_checker (.*);

@@ bench/tb_circle_line_intersection.sv @@
// Self-checking testbench for the circle and line intersection block.
module tb_circle_line_intersection;
    timeunit 1ns;
    timeprecision 1ps;
    import cli_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 366;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDRW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    in_t pending_queries[$];
    out_t expected_hits[$];
    logic [THRW-1:0] tangent_thr = '0;
    int fail_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_left = 0;

    circle_line_intersection dut (.*);

    always #1 aclk = ~aclk;

    // Round a quotient to nearest with ties away from zero.
    function automatic logic signed [127:0] round_quot(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    // Move a frame offset back to world space and clamp it to 16 bits.
    function automatic logic [CW-1:0] sat_world(logic signed [127:0] off,
                                                logic signed [127:0] base);
        logic signed [127:0] s;
        s = off + base;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[CW-1:0];
    endfunction

    // Expected intersection points of one query under a given threshold.
    function automatic out_t predict_hits(in_t q, logic [THRW-1:0] thr);
        logic signed [127:0] cx, cy, rad, ax, ay, bx, by, ex, ey;
        logic signed [127:0] len2, crs, disc, sex, aey, kx, ky, ux, uy;
        logic [127:0] root, cand;
        out_t r;
        r = '0;
        cx = q.center_x; cy = q.center_y; rad = q.radius;
        ax = q.line_ax; ay = q.line_ay; bx = q.line_bx; by = q.line_by;
        ex = bx - ax;
        ey = by - ay;
        if (ex == 0 && ey == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        len2 = ex * ex + ey * ey;
        crs = (ax - cx) * (by - cy) - (bx - cx) * (ay - cy);
        disc = rad * rad * len2 - crs * crs;
        if (disc < 0) return r;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= disc) root = cand;
        end
        sex = (ey < 0) ? -ex : ex;
        aey = (ey < 0) ? -ey : ey;
        kx = crs * ey;
        ky = -(crs * ex);
        ux = sex * $signed(root);
        uy = aey * $signed(root);
        r.hit_count = HITS_ONE;
        r.first_x = sat_world(round_quot(kx + ux, len2), cx);
        r.first_y = sat_world(round_quot(ky + uy, len2), cy);
        if (disc > $signed({65'd0, thr})) begin
            r.hit_count = HITS_TWO;
            r.second_x = sat_world(round_quot(kx - ux, len2), cx);
            r.second_y = sat_world(round_quot(ky - uy, len2), cy);
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        fail_count++;
    endtask

    // Append one query to the pending list.
    task automatic queue_query(in_t q);
        pending_queries.insert(pending_queries.size(), q);
    endtask

    // A query with every bit random.
    function automatic in_t raw_query();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return in_t'(raw[$bits(in_t)-1:0]);
    endfunction

    // A query with the line kept close to the circle so that most rays hit.
    function automatic in_t near_query();
        in_t q;
        int span;
        q.center_x = CW'($urandom);
        q.center_y = CW'($urandom);
        q.radius = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(0, 2000));
        span = q.radius + 64;
        q.line_ax = CW'(q.center_x + $signed(16'($urandom_range(0, 2 * span))) - span);
        q.line_ay = CW'(q.center_y + $signed(16'($urandom_range(0, 2 * span))) - span);
        q.line_bx = CW'(q.center_x + $signed(16'($urandom_range(0, 2 * span))) - span);
        q.line_by = CW'(q.center_y + $signed(16'($urandom_range(0, 2 * span))) - span);
        if ($urandom_range(0, 19) == 0) begin
            q.line_bx = q.line_ax;
            q.line_by = q.line_ay;
        end
        return q;
    endfunction

    function automatic in_t make_query(int cx, int cy, int rad, int ax, int ay,
                                       int bx, int by);
        in_t q;
        q.center_x = CW'(cx); q.center_y = CW'(cy); q.radius = RADW'(rad);
        q.line_ax = CW'(ax); q.line_ay = CW'(ay); q.line_bx = CW'(bx); q.line_by = CW'(by);
        return q;
    endfunction

    // Register write on the configuration port: a setup phase, then an access phase.
    task automatic write_threshold(logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_TANGENT_THRESHOLD, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        tangent_thr <= value[THRW-1:0];
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        do begin
            while (pending_queries.size() != 0 || s_valid || expected_hits.size() != 0)
                @(posedge aclk);
            repeat (80) @(posedge aclk);
        end while (pending_queries.size() != 0 || s_valid || expected_hits.size() != 0);
    endtask

    // Request driver: offers queued queries, with random gaps before the steady phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_hits.insert(expected_hits.size(), predict_hits(s_data, tangent_thr));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_queries.size() != 0) begin
                    s_data <= pending_queries.pop_front();
                    s_valid <= 1'b1;
                    if (!steady && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 7);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls before the steady phase plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 9) == 0) begin
            recv_stall <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $display("result with no request outstanding");
                fail_count++;
            end else begin
                out_t want;
                want = expected_hits.pop_front();
                if (m_data.hit_count != want.hit_count)
                    report_mismatch("hit_count", m_data.hit_count, want.hit_count);
                if (m_data.first_x != want.first_x)
                    report_mismatch("first_x", m_data.first_x, want.first_x);
                if (m_data.first_y != want.first_y)
                    report_mismatch("first_y", m_data.first_y, want.first_y);
                if (m_data.second_x != want.second_x)
                    report_mismatch("second_x", m_data.second_x, want.second_x);
                if (m_data.second_y != want.second_y)
                    report_mismatch("second_y", m_data.second_y, want.second_y);
                if (m_data.degenerate != want.degenerate)
                    report_mismatch("degenerate", m_data.degenerate, want.degenerate);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] thresholds[5];
        thresholds[0] = 64'd0;
        thresholds[1] = 64'h7FFF_FFFF_FFFF_FFFF;
        thresholds[2] = {$urandom, $urandom} >> $urandom_range(20, 40);
        thresholds[3] = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
        thresholds[4] = {$urandom, $urandom} >> $urandom_range(25, 45);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            write_threshold(thresholds[ph]);
            if (ph == 0) begin
                // Coinciding points, tangent, miss, through the center, zero radius.
                queue_query(make_query(0, 0, 256, 100, 100, 100, 100));
                queue_query(make_query(0, 0, 256, -512, 256, 512, 256));
                queue_query(make_query(0, 0, 256, -512, 512, 512, 512));
                queue_query(make_query(0, 0, 256, -512, 0, 512, 0));
                queue_query(make_query(0, 0, 0, -512, 0, 512, 0));
                queue_query(make_query(10, 20, 0, 10, 20, 10, 30));
                queue_query(make_query(0, 0, 300, 0, 500, 0, -500));
                queue_query(make_query(0, 0, 300, 0, -500, 0, 500));
                queue_query(make_query(0, 0, 300, 500, -400, -500, 400));
                // Field extremes and saturation.
                queue_query(make_query(32767, 32767, 32767,
                                       -32768, -32768, 32767, 32767));
                queue_query(make_query(-32768, -32768, 32767,
                                       32767, -32768, -32768, 32767));
                queue_query(make_query(-32768, 32767, 32767,
                                       -32768, -32768, -32768, 32767));
                queue_query(make_query(32767, -32768, 32767,
                                       32767, 32767, -32768, 32767));
                queue_query(make_query(0, 0, 32767, -32768, 0, 32767, 1));
                queue_query(make_query(-32768, -32768, 0,
                                       -32768, -32768, 32767, 32767));
                queue_query(make_query(32767, 32767, 32767,
                                       32767, 32767, 32767, 32767));
                queue_query(make_query(0, 0, 1, 0, 0, 1, 0));
                queue_query(make_query(5, -7, 4, -32768, 32767, 32767, -32768));
            end
            if (ph == 1) hold_req++;
            if (ph == 4) steady = 1'b1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if ($urandom_range(0, 3) == 0)
                    queue_query(raw_query());
                else
                    queue_query(near_query());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
